FILE: hw/rtl/asbd_pkg.sv
// ----------------------------------------------------------------------------
// asbd_pkg
// Shared widths, reset values, register indexes and the frame result record
// of the audio silence boundary detector.
// ----------------------------------------------------------------------------
package asbd_pkg;

  localparam int unsigned SongCountDef    = 64;
  localparam int unsigned FrameSamplesDef = 8192;

  localparam int unsigned SampleW   = 16;
  localparam int unsigned FrameNumW = 24;
  localparam int unsigned ThreshW   = 11;
  localparam int unsigned BpmW      = 11;
  localparam int unsigned CfgW      = 11;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned MsW       = 38;
  localparam int unsigned SongIdxW  = 6;
  localparam int unsigned SumW      = 15;
  localparam int unsigned MagW      = 17;

  localparam logic [SumW-1:0]    SumLimit    = 15'h7FFF;
  localparam logic [ThreshW-1:0] ThreshReset = 11'd4;
  localparam logic [BpmW-1:0]    BpmReset    = 11'd176;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_THRESHOLD    = 2'd0,
    CFG_SCAN_MODE    = 2'd1,
    CFG_BYTES_PER_MS = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic                 frame_silent;
    logic                 interval_found;
    logic [FrameNumW-1:0] interval_first;
    logic [FrameNumW-1:0] interval_final;
    logic                 boundary_valid;
    logic [SongIdxW-1:0]  song_index;
    logic                 list_full;
  } frame_res_t;

endpackage

FILE: hw/rtl/asbd_front.sv
// ----------------------------------------------------------------------------
// asbd_front
// Sample intake: per-frame magnitude sum and sample count, silence run
// tracking and song bookkeeping; pushes one record per completed frame.
// ----------------------------------------------------------------------------
module asbd_front import asbd_pkg::*; #(
  parameter int unsigned MAX_SONG_COUNT    = SongCountDef,
  parameter int unsigned MAX_FRAME_SAMPLES = FrameSamplesDef,
  localparam int unsigned CntW  = $clog2(MAX_FRAME_SAMPLES + 1),
  localparam int unsigned FbW   = CntW + 1,
  localparam int unsigned SongW = $clog2(MAX_SONG_COUNT + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [SampleW-1:0]  sample_i,
  input  logic                       frame_last_i,
  input  logic [FrameNumW-1:0]       frame_number_i,
  input  logic [ThreshW-1:0]         threshold_i,
  input  logic                       scan_mode_i,
  input  logic                       q_full_i,
  output logic                       q_push_o,
  output frame_res_t                 q_res_o,
  output logic [FbW-1:0]             q_bytes_o
);

  logic [SumW-1:0]      sum_q, sum_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [FrameNumW-1:0] run_q;
  logic [SongW-1:0]     songs_q;
  logic                 accept;
  logic [MagW-1:0]      mag;
  logic [MagW:0]        total;
  logic                 silent;
  logic                 found;
  logic                 record;
  logic                 room;
  logic [SongW+SongIdxW-1:0] song_ext;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign q_push_o   = accept && frame_last_i;

  assign mag   = sample_i[SampleW-1] ? (MagW'(0) - MagW'(sample_i)) : MagW'(sample_i);
  assign total = (MagW + 1)'(sum_q) + (MagW + 1)'(mag);
  assign sum_d = (total > (MagW + 1)'(SumLimit)) ? SumLimit : total[SumW-1:0];
  assign cnt_d = (cnt_q < CntW'(MAX_FRAME_SAMPLES)) ? cnt_q + CntW'(1) : cnt_q;

  assign silent   = sum_d < SumLimit;
  assign found    = !silent && (run_q >= FrameNumW'(threshold_i));
  assign room     = songs_q < SongW'(MAX_SONG_COUNT);
  assign record   = found && !scan_mode_i;
  assign song_ext = (SongW + SongIdxW)'(songs_q);

  always_comb begin
    q_res_o              = '0;
    q_res_o.frame_silent = silent;
    if (found) begin
      q_res_o.interval_found = 1'b1;
      q_res_o.interval_first = frame_number_i - run_q;
      q_res_o.interval_final = frame_number_i - FrameNumW'(1);
    end
    if (record) begin
      q_res_o.boundary_valid = room;
      q_res_o.song_index     = room ? song_ext[SongIdxW-1:0] : '0;
      q_res_o.list_full      = !room;
    end
  end

  assign q_bytes_o = {cnt_d, 1'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      cnt_q   <= '0;
      run_q   <= '0;
      songs_q <= '0;
    end else if (accept) begin
      if (frame_last_i) begin
        sum_q <= '0;
        cnt_q <= '0;
        if (silent) begin
          if (run_q != '1) run_q <= run_q + FrameNumW'(1);
        end else begin
          run_q <= '0;
        end
        if (record && room) songs_q <= songs_q + SongW'(1);
      end else begin
        sum_q <= sum_d;
        cnt_q <= cnt_d;
      end
    end
  end

endmodule

FILE: hw/rtl/asbd_fifo.sv
// ----------------------------------------------------------------------------
// asbd_fifo
// Two-entry queue of frame records between intake and back end.
// ----------------------------------------------------------------------------
module asbd_fifo #(
  parameter int unsigned DataW = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [DataW-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [DataW-1:0] data_o,
  output logic             empty_o
);

  logic [DataW-1:0] mem_q [2];
  logic             wptr_q;
  logic             rptr_q;
  logic [1:0]       cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) wptr_q <= !wptr_q;
      if (pop_i)  rptr_q <= !rptr_q;
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("queue underflow");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("queue count out of range");

endmodule

FILE: hw/rtl/asbd_back.sv
// ----------------------------------------------------------------------------
// asbd_back
// Back end: boundary time as first frame times frame bytes over bytes per
// millisecond (one multiply, then restoring division one bit a cycle), and
// the registered result stage.
// ----------------------------------------------------------------------------
module asbd_back import asbd_pkg::*; #(
  parameter int unsigned MAX_FRAME_SAMPLES = FrameSamplesDef,
  localparam int unsigned CntW = $clog2(MAX_FRAME_SAMPLES + 1),
  localparam int unsigned FbW  = CntW + 1,
  localparam int unsigned PW   = FrameNumW + FbW,
  localparam int unsigned DcW  = $clog2(PW)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_empty_i,
  output logic                 q_pop_o,
  input  frame_res_t           q_res_i,
  input  logic [FbW-1:0]       q_bytes_i,
  input  logic [BpmW-1:0]      bpm_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 frame_silent_o,
  output logic                 interval_found_o,
  output logic [FrameNumW-1:0] interval_first_o,
  output logic [FrameNumW-1:0] interval_final_o,
  output logic                 boundary_valid_o,
  output logic [MsW-1:0]       boundary_ms_o,
  output logic [SongIdxW-1:0]  song_index_o,
  output logic                 list_full_o
);

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_OUT} state_e;

  state_e          state_q;
  frame_res_t      res_q;
  logic [FbW-1:0]  bytes_q;
  logic [PW-1:0]   prod_q;
  logic [BpmW:0]   rem_q;
  logic [DcW-1:0]  dcnt_q;
  logic [BpmW-1:0] divisor;
  logic [BpmW:0]   rem_sh;
  logic            ge;
  logic [PW+MsW-1:0] quot_ext;

  assign divisor = (bpm_i == '0) ? BpmW'(1) : bpm_i;
  assign rem_sh  = {rem_q[BpmW-1:0], prod_q[PW-1]};
  assign ge      = rem_sh >= {1'b0, divisor};

  assign q_pop_o = !q_empty_i &&
                   (state_q == S_IDLE || (state_q == S_OUT && !out_stall_i));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      res_q   <= '0;
      bytes_q <= '0;
      prod_q  <= '0;
      rem_q   <= '0;
      dcnt_q  <= '0;
    end else begin
      unique case (state_q)
        S_IDLE, S_OUT: begin
          if (q_pop_o) begin
            res_q   <= q_res_i;
            bytes_q <= q_bytes_i;
            state_q <= q_res_i.boundary_valid ? S_MUL : S_OUT;
          end else if (state_q == S_OUT && !out_stall_i) begin
            state_q <= S_IDLE;
          end
        end
        S_MUL: begin
          prod_q  <= PW'(res_q.interval_first) * PW'(bytes_q);
          rem_q   <= '0;
          dcnt_q  <= '0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          prod_q <= {prod_q[PW-2:0], ge};
          rem_q  <= ge ? rem_sh - {1'b0, divisor} : rem_sh;
          dcnt_q <= dcnt_q + DcW'(1);
          if (dcnt_q == DcW'(PW - 1)) state_q <= S_OUT;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign quot_ext = (PW + MsW)'(prod_q);

  assign out_valid_o      = state_q == S_OUT;
  assign frame_silent_o   = res_q.frame_silent;
  assign interval_found_o = res_q.interval_found;
  assign interval_first_o = res_q.interval_first;
  assign interval_final_o = res_q.interval_final;
  assign boundary_valid_o = res_q.boundary_valid;
  assign boundary_ms_o    = res_q.boundary_valid ? quot_ext[MsW-1:0] : '0;
  assign song_index_o     = res_q.song_index;
  assign list_full_o      = res_q.list_full;

  a_boundary_needs_interval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && boundary_valid_o) |-> interval_found_o)
    else $error("boundary without interval");
  a_full_excludes_boundary: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && list_full_o) |-> (interval_found_o && !boundary_valid_o))
    else $error("list full with boundary");
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(res_q) && $stable(prod_q)))
    else $error("stalled result changed");
  a_div_done_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && $past(state_q) == S_MUL) |-> dcnt_q == '0)
    else $error("division count not cleared");

endmodule

FILE: hw/rtl/audio_silence_boundary_detector.sv
// ----------------------------------------------------------------------------
// audio_silence_boundary_detector
// Frame silence classification, silence interval reporting and song
// boundary timing from a stream of 16-bit PCM samples.
// ----------------------------------------------------------------------------
//  channel  direction  handshake              payload
//  in       sink       in_valid_i/in_stall_o  sample, frame_last, frame_number
//  out      source     out_valid_o/out_stall_i frame result, one per frame
//  cfg      sink       cfg_we_i               cfg_idx_i, cfg_data_i
//
//  A sample is taken every cycle while the two-entry frame queue has room.
//  A frame result enters the back end's output stage when it is popped from
//  the queue; when a boundary time is computed, it first passes a multiply
//  step, then the restoring divider gives one quotient bit per cycle.
//  Reset clears all counters and loads the register reset values.
//  A stalled result stays in the output stage; intake stops only when the
//  queue is full.
// ----------------------------------------------------------------------------
module audio_silence_boundary_detector import asbd_pkg::*; #(
  parameter int unsigned MAX_SONG_COUNT    = SongCountDef,
  parameter int unsigned MAX_FRAME_SAMPLES = FrameSamplesDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [CfgIdxW-1:0]         cfg_idx_i,
  input  logic [CfgW-1:0]            cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [SampleW-1:0]  sample_i,
  input  logic                       frame_last_i,
  input  logic [FrameNumW-1:0]       frame_number_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       frame_silent_o,
  output logic                       interval_found_o,
  output logic [FrameNumW-1:0]       interval_first_o,
  output logic [FrameNumW-1:0]       interval_final_o,
  output logic                       boundary_valid_o,
  output logic [MsW-1:0]             boundary_ms_o,
  output logic [SongIdxW-1:0]        song_index_o,
  output logic                       list_full_o
);

  localparam int unsigned CntW = $clog2(MAX_FRAME_SAMPLES + 1);
  localparam int unsigned FbW  = CntW + 1;
  localparam int unsigned QW   = $bits(frame_res_t) + FbW;

  logic [ThreshW-1:0] thresh_q;
  logic               scan_q;
  logic [BpmW-1:0]    bpm_q;

  logic               q_push;
  logic               q_pop;
  logic               q_full;
  logic               q_empty;
  frame_res_t         push_res;
  frame_res_t         pop_res;
  logic [FbW-1:0]     push_bytes;
  logic [FbW-1:0]     pop_bytes;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= ThreshReset;
      scan_q   <= 1'b0;
      bpm_q    <= BpmReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_THRESHOLD:    thresh_q <= cfg_data_i[ThreshW-1:0];
        CFG_SCAN_MODE:    scan_q   <= cfg_data_i[0];
        CFG_BYTES_PER_MS: bpm_q    <= cfg_data_i[BpmW-1:0];
        default:          ;
      endcase
    end
  end

  asbd_front #(
    .MAX_SONG_COUNT   (MAX_SONG_COUNT),
    .MAX_FRAME_SAMPLES(MAX_FRAME_SAMPLES)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .sample_i      (sample_i),
    .frame_last_i  (frame_last_i),
    .frame_number_i(frame_number_i),
    .threshold_i   (thresh_q),
    .scan_mode_i   (scan_q),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_res_o       (push_res),
    .q_bytes_o     (push_bytes)
  );

  asbd_fifo #(
    .DataW(QW)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i ({push_res, push_bytes}),
    .full_o (q_full),
    .pop_i  (q_pop),
    .data_o ({pop_res, pop_bytes}),
    .empty_o(q_empty)
  );

  asbd_back #(
    .MAX_FRAME_SAMPLES(MAX_FRAME_SAMPLES)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_empty_i       (q_empty),
    .q_pop_o         (q_pop),
    .q_res_i         (pop_res),
    .q_bytes_i       (pop_bytes),
    .bpm_i           (bpm_q),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .frame_silent_o  (frame_silent_o),
    .interval_found_o(interval_found_o),
    .interval_first_o(interval_first_o),
    .interval_final_o(interval_final_o),
    .boundary_valid_o(boundary_valid_o),
    .boundary_ms_o   (boundary_ms_o),
    .song_index_o    (song_index_o),
    .list_full_o     (list_full_o)
  );

endmodule
